// File: rtl/s2l_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_pkg
// Shared constants, types and the sRGB linearization table for the
// sRGB to CIELAB (D65) pixel pipeline.
// ----------------------------------------------------------------------------
package s2l_pkg;

   // output fixed point and internal Q format
   localparam int FRACTION_BITS = 6;
   localparam int QBITS         = 24;
   localparam int RND_SHIFT     = QBITS - FRACTION_BITS;

   // datapath widths
   localparam int CODE_W    = 8;
   localparam int LIN_W     = 25;
   localparam int COEF_W    = 20;
   localparam int PROD_W    = LIN_W + COEF_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int T_W       = 25;
   localparam int ROOT_BITS = 26;
   localparam int F_W       = ROOT_BITS;
   localparam int SQ_W      = 28;
   localparam int CUBE_W    = 30;
   localparam int LAB_W     = 37;

   // f(t) constants
   localparam logic [T_W-1:0] EPS_Q       = 25'd148579;
   localparam int             LIN_DIV     = 1160;
   localparam logic [13:0]    LIN_MUL     = 14'd9033;
   localparam logic [31:0]    LIN_OFS     = 32'd2684355140;
   localparam int             RECIP_SHIFT = 42;
   localparam logic [31:0]    LIN_RECIP   = 32'((64'd1 << RECIP_SHIFT) / 64'd1160);

   // output limits
   localparam int L_LIMIT = 100 << FRACTION_BITS;
   localparam int L_MAX   = (L_LIMIT > 8191) ? 8191 : L_LIMIT;
   localparam int AB_MAX  = 8191;
   localparam int AB_MIN  = -8192;

   // xyz matrix, already divided by the white point, Q20
   typedef logic [0:2][0:2][COEF_W-1:0] coef_mat_type;
   localparam coef_mat_type XYZ_COEF = '{
      '{20'd455036, 20'd394490, 20'd199065},
      '{20'd223004, 20'd749891, 20'd75681},
      '{20'd18620,  20'd114793, 20'd915235}
   };

   // items between pipeline sections
   typedef struct packed {
      logic [2:0][T_W-1:0] t;
      logic                eob;
   } t_item_type;

   typedef struct packed {
      logic [2:0][F_W-1:0] f;
      logic                eob;
   } f_item_type;

   // srgb linearization table, built at elaboration
   typedef logic [255:0][LIN_W-1:0] lin_table_type;

   function automatic lin_table_type build_lin_table();
      lin_table_type   tab;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned y;
      longint unsigned cand;
      longint unsigned y2;
      longint unsigned p5;
      longint unsigned v;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            v = (64'(c) * 64'd100 * 64'd16777216 + 64'd164730) / 64'd329460;
         end else begin
            t  = ((64'd1000 * 64'(c) + 64'd14025) * 64'd16777216 + 64'd134512)
                 / 64'd269025;
            t2 = (t * t) >> 24;
            y  = 64'd0;
            for (int b = 24; b >= 0; b--) begin
               cand = y | (64'd1 << b);
               y2   = (cand * cand) >> 24;
               p5   = (((y2 * y2) >> 24) * cand) >> 24;
               if (p5 <= t2) y = cand;
            end
            v = (t2 * y + 64'd8388608) >> 24;
         end
         tab[c] = v[LIN_W-1:0];
      end
      return tab;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

// File: rtl/srgb_to_lab_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_lab_pixel_core
// 8-bit sRGB pixel to CIELAB (D65), L/a/b with 6 fraction bits.
//
//   channel  direction  fields
//   req      in         red, green, blue, end_of_block
//   rsp      out        lightness, green_red, blue_yellow, end_of_block_out
//
// One pixel per clock sustained while rsp_ready holds. Stages: lookup and
// matrix, the cube root (two stages per root bit, 26 bits), then L/a/b
// forming, rounding and saturation. Each stage advances when it is
// empty or its successor advances, so a stalled rsp side fills the pipe
// without loss. Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module srgb_to_lab_pixel_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic               req_end_of_block,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [12:0]        rsp_lightness,
   output logic signed [13:0] rsp_green_red,
   output logic signed [13:0] rsp_blue_yellow,
   output logic               rsp_end_of_block_out
);
   import s2l_pkg::*;

   logic       xyz_valid, xyz_ready, f_valid, f_ready;
   t_item_type xyz_item;
   f_item_type f_item;

   // linearize and convert to xyz
   s2l_xyz u_xyz (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .eob       (req_end_of_block),
      .out_valid (xyz_valid),
      .out_ready (xyz_ready),
      .out_item  (xyz_item)
   );

   // f(t) per component
   s2l_cbrt u_cbrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xyz_valid),
      .in_ready  (xyz_ready),
      .in_item   (xyz_item),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   // l, a, b and output register
   s2l_lab u_lab (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (f_valid),
      .in_ready    (f_ready),
      .in_item     (f_item),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .lightness   (rsp_lightness),
      .green_red   (rsp_green_red),
      .blue_yellow (rsp_blue_yellow),
      .eob_out     (rsp_end_of_block_out)
   );

endmodule

// File: rtl/s2l_xyz.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_xyz
// Three stages: table linearization, matrix products, sum and rescale to
// white-normalized XYZ in Q24.
// ----------------------------------------------------------------------------
module s2l_xyz (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [7:0]            red,
   input  logic [7:0]            green,
   input  logic [7:0]            blue,
   input  logic                  eob,
   output logic                  out_valid,
   input  logic                  out_ready,
   output s2l_pkg::t_item_type   out_item
);
   import s2l_pkg::*;

   logic                             v1_ff, v2_ff, v3_ff;
   logic                             en1, en2, en3;
   logic [2:0][LIN_W-1:0]            lin_ff;
   logic [2:0][LIN_W-1:0]            lin_in;
   logic [2:0][2:0][PROD_W-1:0]      prod_ff;
   logic [2:0][2:0][PROD_W-1:0]      prod_in;
   logic [2:0][T_W-1:0]              t_ff;
   logic [2:0][T_W-1:0]              t_in;
   logic [2:0][SUM_W-1:0]            sum;
   logic                             eob1_ff, eob2_ff, eob3_ff;

   // stage enables, each stage moves when empty or when the next moves
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // linearization lookup
   assign lin_in[0] = LIN_TABLE[red];
   assign lin_in[1] = LIN_TABLE[green];
   assign lin_in[2] = LIN_TABLE[blue];

   // matrix products and row sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_W'(lin_ff[j]) * PROD_W'(XYZ_COEF[i][j]);
         end
         sum[i]  = SUM_W'(prod_ff[i][0]) + SUM_W'(prod_ff[i][1])
                 + SUM_W'(prod_ff[i][2]) + (SUM_W'(1) << 19);
         t_in[i] = sum[i][T_W+19:20];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en1) begin
         lin_ff  <= lin_in;
         eob1_ff <= eob;
      end
      if (en2) begin
         prod_ff <= prod_in;
         eob2_ff <= eob1_ff;
      end
      if (en3) begin
         t_ff    <= t_in;
         eob3_ff <= eob2_ff;
      end
   end

   assign out_valid    = v3_ff;
   assign out_item.t   = t_ff;
   assign out_item.eob = eob3_ff;

endmodule

// File: rtl/s2l_cbrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_cbrt
// CIELAB f(t) on three lanes: a bit-by-bit cube root, two stages per bit
// (square, then cube and compare), with the kappa linear segment computed
// alongside in the first four stages through a reciprocal divide.
// ----------------------------------------------------------------------------
module s2l_cbrt (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  s2l_pkg::t_item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output s2l_pkg::f_item_type   out_item
);
   import s2l_pkg::*;

   localparam int NSTG = 2 * ROOT_BITS;

   typedef struct packed {
      logic [T_W-1:0]  t;
      logic [F_W-1:0]  y;
      logic [SQ_W-1:0] sq;
      logic [31:0]     n;
      logic [31:0]     q;
      logic [31:0]     qm;
      logic [F_W-1:0]  lin;
   } lane_type;

   typedef struct packed {
      lane_type [2:0] lane;
      logic           eob;
   } stage_type;

   stage_type        stg_ff [NSTG];
   stage_type        stg_in [NSTG];
   stage_type        src    [NSTG];
   logic [NSTG-1:0]  v_ff;
   logic [NSTG:0]    en;

   // stage enables, chained from the output
   assign en[NSTG] = out_ready;
   genvar k;
   generate
      for (k = 0; k < NSTG; k++) begin : g_en
         assign en[k] = !v_ff[k] || en[k+1];
      end
   endgenerate
   assign in_ready = en[0];

   // entry of the first stage
   always_comb begin
      src[0].eob = in_item.eob;
      for (int i = 0; i < 3; i++) begin
         src[0].lane[i]   = '0;
         src[0].lane[i].t = in_item.t[i];
      end
   end

   generate
      for (k = 0; k < NSTG; k++) begin : g_stg
         localparam int BITPOS = ROOT_BITS - 1 - k / 2;

         if (k > 0) begin : g_src
            assign src[k] = stg_ff[k-1];
         end

         // one half step of the root, and a step of the linear segment where this stage has one
         always_comb begin
            logic [F_W-1:0]    cand;
            logic [2*F_W-1:0]  sq_full;
            logic [SQ_W+F_W-1:0] cube_full;
            logic [CUBE_W-1:0] cube;
            logic [31:0]       rem;
            logic [63:0]       recip_full;
            stg_in[k] = src[k];
            for (int i = 0; i < 3; i++) begin
               cand      = src[k].lane[i].y | (F_W'(1) << BITPOS);
               sq_full   = (2*F_W)'(cand) * (2*F_W)'(cand);
               cube_full = (SQ_W+F_W)'(src[k].lane[i].sq) * (SQ_W+F_W)'(cand);
               cube      = cube_full[QBITS+CUBE_W-1:QBITS];
               rem       = src[k].lane[i].n - src[k].lane[i].qm;
               recip_full = 64'(src[k].lane[i].n) * 64'(LIN_RECIP);
               if ((k % 2) == 0) begin
                  stg_in[k].lane[i].sq = sq_full[QBITS+SQ_W-1:QBITS];
               end else if (cube <= CUBE_W'(src[k].lane[i].t)) begin
                  stg_in[k].lane[i].y = cand;
               end
               if (k == 0) begin
                  stg_in[k].lane[i].n = 32'(32'(src[k].lane[i].t) * 32'(LIN_MUL)) + LIN_OFS;
               end
               if (k == 1) begin
                  stg_in[k].lane[i].q = 32'(recip_full >> RECIP_SHIFT);
               end
               if (k == 2) begin
                  stg_in[k].lane[i].qm = 32'(src[k].lane[i].q * 32'(LIN_DIV));
               end
               if (k == 3) begin
                  if (rem >= 32'(LIN_DIV)) begin
                     stg_in[k].lane[i].lin = F_W'(src[k].lane[i].q + 32'd1);
                  end else begin
                     stg_in[k].lane[i].lin = F_W'(src[k].lane[i].q);
                  end
               end
            end
         end

         // valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
            end
         end

         // payload
         always_ff @(posedge clock) begin
            if (en[k]) stg_ff[k] <= stg_in[k];
         end
      end
   endgenerate

   // pick the cube root above epsilon, the linear segment otherwise
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_item.f[i] = (stg_ff[NSTG-1].lane[i].t > EPS_Q) ?
                         stg_ff[NSTG-1].lane[i].y : stg_ff[NSTG-1].lane[i].lin;
      end
   end
   assign out_item.eob = stg_ff[NSTG-1].eob;
   assign out_valid    = v_ff[NSTG-1];

endmodule

// File: rtl/s2l_lab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_lab
// Forms L, a and b from f(x), f(y), f(z), then rounds half away from zero to
// the output fraction and saturates. Two stages, the last is the output.
// ----------------------------------------------------------------------------
module s2l_lab (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  s2l_pkg::f_item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [12:0]           lightness,
   output logic signed [13:0]    green_red,
   output logic signed [13:0]    blue_yellow,
   output logic                  eob_out
);
   import s2l_pkg::*;

   logic                     va_ff, vb_ff, ena, enb;
   logic signed [LAB_W-1:0]  fx, fy, fz;
   logic signed [LAB_W-1:0]  raw_in [3];
   logic signed [LAB_W-1:0]  raw_ff [3];
   logic signed [LAB_W-1:0]  rnd    [3];
   logic                     eoba_ff;
   logic [12:0]              l_in;
   logic signed [13:0]       a_in, b_in;

   assign enb      = !vb_ff || out_ready;
   assign ena      = !va_ff || enb;
   assign in_ready = ena;

   // scaled differences in q24
   assign fx = LAB_W'(in_item.f[0]);
   assign fy = LAB_W'(in_item.f[1]);
   assign fz = LAB_W'(in_item.f[2]);
   assign raw_in[0] = fy * LAB_W'(116) - (LAB_W'(16) <<< QBITS);
   assign raw_in[1] = (fx - fy) * LAB_W'(500);
   assign raw_in[2] = (fy - fz) * LAB_W'(200);

   // round half away from zero, then saturate
   always_comb begin
      logic [LAB_W-1:0] mag;
      logic [LAB_W-1:0] rmag;
      for (int i = 0; i < 3; i++) begin
         mag    = raw_ff[i][LAB_W-1] ? LAB_W'(-raw_ff[i]) : LAB_W'(raw_ff[i]);
         rmag   = (mag + (LAB_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
         rnd[i] = raw_ff[i][LAB_W-1] ? -signed'(rmag) : signed'(rmag);
      end
      if (rnd[0] < 0) begin
         l_in = '0;
      end else if (rnd[0] > LAB_W'(L_MAX)) begin
         l_in = 13'(L_MAX);
      end else begin
         l_in = rnd[0][12:0];
      end
      if (rnd[1] > LAB_W'(AB_MAX)) a_in = 14'(AB_MAX);
      else if (rnd[1] < LAB_W'(AB_MIN)) a_in = 14'(AB_MIN);
      else a_in = rnd[1][13:0];
      if (rnd[2] > LAB_W'(AB_MAX)) b_in = 14'(AB_MAX);
      else if (rnd[2] < LAB_W'(AB_MIN)) b_in = 14'(AB_MIN);
      else b_in = rnd[2][13:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ena) va_ff <= in_valid;
         if (enb) vb_ff <= va_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ena) begin
         raw_ff  <= raw_in;
         eoba_ff <= in_item.eob;
      end
      if (enb) begin
         lightness   <= l_in;
         green_red   <= a_in;
         blue_yellow <= b_in;
         eob_out     <= eoba_ff;
      end
   end

   assign out_valid = vb_ff;

endmodule
